// File: design/grid_bin_max_aggregator_assert.svh
// assertion macros for the grid binning block
`ifndef GRID_BIN_MAX_AGGREGATOR_ASSERT_SVH
`define GRID_BIN_MAX_AGGREGATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GBA_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define GBA_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define GBA_ASSERT_IMP(label, clk, rst, a, c)
`define GBA_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// File: design/gba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gba_pkg;
   localparam int CELL_COUNT_DEF = 1024;
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_FAR_X    = 3'd2;
   localparam logic [2:0] REG_FAR_Y    = 3'd3;
   localparam logic [2:0] REG_CELL     = 3'd4;
   localparam logic [2:0] REG_COLUMNS  = 3'd5;
   localparam logic [2:0] REG_ROWS     = 3'd6;
   localparam logic [31:0] EMPTY_WORD = 32'h8000_0000;
   typedef struct packed {
      logic [1:0]  op;
      logic [16:0] cell_no;
      logic [31:0] dir;
      logic [31:0] den;
      logic [31:0] expo;
      logic [31:0] coef;
   } cmd_type;
endpackage
`default_nettype wire

// File: design/gba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: design/gba_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module gba_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [30:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [30:0] d_ff, d_in;
   logic [5:0]  n_ff, n_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      run_in = run_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[31]} - {2'b00, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = 6'd0; run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
         n_in = n_ff + 6'd1;
         if (n_ff == 6'd31) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

// File: design/gba_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gba_front #(
   parameter int CELL_COUNT = gba_pkg::CELL_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        op,
   input  wire logic [31:0]       px,
   input  wire logic [31:0]       py,
   input  wire logic [31:0]       dir,
   input  wire logic [31:0]       den,
   input  wire logic [31:0]       expo,
   input  wire logic [31:0]       coef,
   input  wire logic [9:0]        cidx,
   input  wire logic [31:0]       origin_x,
   input  wire logic [31:0]       origin_y,
   input  wire logic [31:0]       far_x,
   input  wire logic [31:0]       far_y,
   input  wire logic [30:0]       cell_size,
   input  wire logic [10:0]       columns,
   input  wire logic [10:0]       rows,
   output logic                   q_push,
   output gba_pkg::cmd_type       q_data,
   input  wire logic              q_full
);
   localparam logic [2:0] S_IDLE = 3'd0, S_DX = 3'd1, S_DY = 3'd2,
                          S_CELL = 3'd3, S_PUSH = 3'd4, S_MUL = 3'd5;
   localparam logic [16:0] CELL_PENDING = 17'h1ffff;
   logic [2:0]  st_ff, st_in;
   gba_pkg::cmd_type c_ff, c_in;
   logic [31:0] px_ff, py_ff, px_in, py_in;
   logic        drop_ff, drop_in, nearx_ff, nearx_in, neary_ff, neary_in;
   logic [31:0] col_ff, col_in;
   logic [31:0] row_ff, row_in;
   logic [21:0] prod_ff, prod_in;
   logic        dv_start;
   logic [31:0] dv_num;
   logic        dv_done;
   logic [31:0] dv_q;
   logic [32:0] offx, offy, adjq;
   logic [33:0] sumx, sumy;
   logic [32:0] cellsum;

   gba_divider u_div (.clock, .reset, .start(dv_start), .dividend(dv_num),
                      .divisor(cell_size), .done(dv_done), .quotient(dv_q));

   assign busy = (st_ff != S_IDLE);

   always_comb begin
      st_in = st_ff; c_in = c_ff; px_in = px_ff; py_in = py_ff;
      drop_in = drop_ff; nearx_in = nearx_ff; neary_in = neary_ff;
      col_in = col_ff; row_in = row_ff; prod_in = prod_ff;
      dv_start = 1'b0; dv_num = '0; q_push = 1'b0;
      offx = {px_ff[31], px_ff} - {origin_x[31], origin_x};
      offy = {py_ff[31], py_ff} - {origin_y[31], origin_y};
      sumx = {{2{px_ff[31]}}, px_ff} + {3'b000, cell_size};
      sumy = {{2{py_ff[31]}}, py_ff} + {3'b000, cell_size};
      adjq = {1'b0, dv_q};
      cellsum = {1'b0, col_ff} + {11'd0, prod_ff};
      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               c_in.op = op; c_in.dir = dir; c_in.den = den;
               c_in.expo = expo; c_in.coef = coef;
               c_in.cell_no = {7'd0, cidx};
               px_in = px; py_in = py;
               drop_in = (op == gba_pkg::OP_ADD) && (cell_size == '0);
               if (op == gba_pkg::OP_ADD) st_in = S_DX;
               else st_in = S_PUSH;
            end
         end
         S_DX: begin
            if (offx[32] || offy[32] || drop_ff) begin
               drop_in = 1'b1; st_in = S_PUSH;
            end else begin
               dv_start = 1'b1; dv_num = offx[31:0];
               nearx_in = $signed(sumx) > $signed({{2{far_x[31]}}, far_x});
               neary_in = $signed(sumy) > $signed({{2{far_y[31]}}, far_y});
               st_in = S_DY;
            end
         end
         S_DY: begin
            if (dv_done) begin
               adjq = {1'b0, dv_q} - {32'd0, (nearx_ff && dv_q != '0)};
               col_in = adjq[31:0];
               dv_start = 1'b1; dv_num = offy[31:0];
               st_in = S_MUL;
            end
         end
         S_MUL: begin
            if (dv_done) begin
               adjq = {1'b0, dv_q} - {32'd0, (neary_ff && dv_q != '0)};
               row_in = adjq[31:0];
               st_in = S_CELL;
            end
         end
         S_CELL: begin
            if (col_ff >= {21'd0, columns} || row_ff >= {21'd0, rows}) begin
               drop_in = 1'b1; st_in = S_PUSH;
            end else begin
               prod_in = {11'd0, row_ff[10:0]} * {11'd0, columns};
               st_in = S_PUSH;
               c_in.cell_no = CELL_PENDING;
               drop_in = 1'b0;
               col_in = col_ff;
               c_in.op = gba_pkg::OP_ADD;
               // cell number still to be summed
               nearx_in = 1'b1;
            end
         end
         S_PUSH: begin
            if (c_ff.op == gba_pkg::OP_ADD && nearx_ff && c_ff.cell_no == CELL_PENDING) begin
               if (cellsum >= 33'(CELL_COUNT)) drop_in = 1'b1;
               c_in.cell_no = cellsum[16:0];
               nearx_in = 1'b0;
            end else if (!q_full) begin
               if (!drop_ff && c_ff.op != gba_pkg::OP_SPARE) q_push = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign q_data = c_ff;

   always_ff @(posedge clock) begin
      c_ff <= c_in; px_ff <= px_in; py_ff <= py_in; col_ff <= col_in;
      row_ff <= row_in; prod_ff <= prod_in;
      nearx_ff <= nearx_in; neary_ff <= neary_in; drop_ff <= drop_in;
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
   end
endmodule
`default_nettype wire

// File: design/gba_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gba_back #(
   parameter int CELL_COUNT = gba_pkg::CELL_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire gba_pkg::cmd_type  q_data,
   output logic                   q_pop,
   output logic                   idle,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_cell_direction,
   output logic [31:0]            rsp_cell_density,
   output logic [31:0]            rsp_cell_exponent,
   output logic [31:0]            rsp_cell_coefficient
);
   localparam int AW = $clog2(CELL_COUNT);
   localparam logic [1:0] S_IDLE = 2'd0, S_RD = 2'd1, S_WB = 2'd2, S_CLR = 2'd3;
   logic [1:0] st_ff, st_in;
   gba_pkg::cmd_type c_ff, c_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] addr, val_addr;
   logic [31:0] r_dir, r_den, r_exp, r_coef;
   logic [1:0] r_val, val_data;
   logic we_dir, we_den, we_val;
   logic take_dir, take_den, inrange;
   logic [32:0] mdir, mden;
   logic rsp_ff;
   logic [31:0] o_dir_ff, o_den_ff, o_exp_ff, o_coef_ff;

   assign addr = st_ff == S_IDLE ? q_data.cell_no[AW-1:0] : c_ff.cell_no[AW-1:0];
   assign inrange = c_ff.cell_no < 17'(CELL_COUNT);
   assign mdir = c_ff.dir[31] ? 33'd0 - {1'b1, c_ff.dir} : {1'b0, c_ff.dir};
   assign mden = c_ff.den[31] ? 33'd0 - {1'b1, c_ff.den} : {1'b0, c_ff.den};
   assign take_dir = !r_val[1] || $signed({r_dir[31], r_dir}) < $signed(mdir);
   assign take_den = !r_val[0] || $signed({r_den[31], r_den}) < $signed(mden);
   assign we_dir = st_ff == S_WB && take_dir;
   assign we_den = st_ff == S_WB && take_den;
   // valid bits: direction high, density low
   assign we_val = st_ff == S_CLR || we_dir || we_den;
   assign val_addr = st_ff == S_CLR ? clr_ff : addr;
   assign val_data = st_ff == S_CLR ? 2'b00 : {r_val[1] | take_dir, r_val[0] | take_den};

   gba_ram #(.WIDTH(2), .DEPTH(CELL_COUNT)) u_val (.clock, .wr_en(we_val),
      .wr_addr(val_addr), .wr_data(val_data), .rd_addr(addr), .rd_data(r_val));
   gba_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_dir (.clock, .wr_en(we_dir),
      .wr_addr(addr), .wr_data(c_ff.dir), .rd_addr(addr), .rd_data(r_dir));
   gba_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_den (.clock, .wr_en(we_den),
      .wr_addr(addr), .wr_data(c_ff.den), .rd_addr(addr), .rd_data(r_den));
   gba_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_exp (.clock, .wr_en(we_den),
      .wr_addr(addr), .wr_data(c_ff.expo), .rd_addr(addr), .rd_data(r_exp));
   gba_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_coef (.clock, .wr_en(we_den),
      .wr_addr(addr), .wr_data(c_ff.coef), .rd_addr(addr), .rd_data(r_coef));

   always_comb begin
      st_in = st_ff; c_in = c_ff; clr_in = clr_ff; q_pop = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1; c_in = q_data;
               if (q_data.op == gba_pkg::OP_CLEAR) begin
                  st_in = S_CLR; clr_in = '0;
               end else st_in = S_RD;
            end
         end
         S_RD: st_in = (c_ff.op == gba_pkg::OP_ADD) ? S_WB : S_IDLE;
         S_WB: st_in = S_IDLE;
         S_CLR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELL_COUNT - 1)) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign idle = st_ff == S_IDLE && !q_valid;

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      if (st_ff == S_RD && inrange && r_val[1]) o_dir_ff <= r_dir;
      else o_dir_ff <= gba_pkg::EMPTY_WORD;
      if (st_ff == S_RD && inrange && r_val[0]) begin
         o_den_ff <= r_den; o_exp_ff <= r_exp; o_coef_ff <= r_coef;
      end else begin
         o_den_ff <= gba_pkg::EMPTY_WORD; o_exp_ff <= gba_pkg::EMPTY_WORD;
         o_coef_ff <= gba_pkg::EMPTY_WORD;
      end
      if (reset) begin
         st_ff <= S_CLR; clr_ff <= '0; rsp_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in;
         rsp_ff <= st_ff == S_RD && c_ff.op == gba_pkg::OP_READ;
      end
   end
   assign rsp_valid = rsp_ff;
   assign rsp_cell_direction = o_dir_ff;
   assign rsp_cell_density = o_den_ff;
   assign rsp_cell_exponent = o_exp_ff;
   assign rsp_cell_coefficient = o_coef_ff;
endmodule
`default_nettype wire

// File: design/grid_bin_max_aggregator.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  handshake                 contents
// req      start / busy              opcode, point, values, cell index
// rsp      rsp_valid strobe          kept cell contents
// csr      csr_valid / csr_ready     register index, data
// an add holds busy through two serial divides, one per axis, then the cell and push steps
// a point before the origin or with zero cell size skips the divides, as does a read or clear
// the back reads a cell in S_RD and an add then writes it back in S_WB; a clear steps S_CLR over every cell
// reset is synchronous; after it the back runs a clearing pass over every cell
// a two-word queue parts front and back; the front stalls only while it is full
module grid_bin_max_aggregator #(
   parameter int CELL_COUNT = gba_pkg::CELL_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_point_x,
   input  wire logic [31:0] req_point_y,
   input  wire logic [31:0] req_direction_value,
   input  wire logic [31:0] req_density,
   input  wire logic [31:0] req_exponent,
   input  wire logic [31:0] req_coefficient,
   input  wire logic [9:0]  req_cell_index,
   output logic             rsp_valid,
   output logic [31:0]      rsp_cell_direction,
   output logic [31:0]      rsp_cell_density,
   output logic [31:0]      rsp_cell_exponent,
   output logic [31:0]      rsp_cell_coefficient,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
`include "grid_bin_max_aggregator_assert.svh"
   logic [31:0] ox_ff, oy_ff, fx_ff, fy_ff;
   logic [30:0] cs_ff;
   logic [10:0] cols_ff, rows_ff;
   logic front_busy, push, pop, back_idle;
   gba_pkg::cmd_type push_data, head;
   gba_pkg::cmd_type qd_ff [2];
   logic [1:0] cnt_ff;
   logic wp_ff, rp_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0; oy_ff <= '0; fx_ff <= '0; fy_ff <= '0;
         cs_ff <= 31'd65536; cols_ff <= 11'd1; rows_ff <= 11'd1;
      end else if (csr_valid) begin
         case (csr_index)
            gba_pkg::REG_ORIGIN_X: ox_ff <= csr_data;
            gba_pkg::REG_ORIGIN_Y: oy_ff <= csr_data;
            gba_pkg::REG_FAR_X:    fx_ff <= csr_data;
            gba_pkg::REG_FAR_Y:    fy_ff <= csr_data;
            gba_pkg::REG_CELL:     cs_ff <= csr_data[30:0];
            gba_pkg::REG_COLUMNS:  cols_ff <= csr_data[10:0];
            gba_pkg::REG_ROWS:     rows_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   gba_front #(.CELL_COUNT(CELL_COUNT)) u_front (.clock, .reset, .start,
      .busy(front_busy), .op(req_opcode), .px(req_point_x), .py(req_point_y),
      .dir(req_direction_value), .den(req_density), .expo(req_exponent),
      .coef(req_coefficient), .cidx(req_cell_index), .origin_x(ox_ff),
      .origin_y(oy_ff), .far_x(fx_ff), .far_y(fy_ff), .cell_size(cs_ff),
      .columns(cols_ff), .rows(rows_ff), .q_push(push), .q_data(push_data),
      .q_full(cnt_ff == 2'd2));

   assign head = qd_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push) qd_ff[wp_ff] <= push_data;
      if (reset) begin
         cnt_ff <= '0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   gba_back #(.CELL_COUNT(CELL_COUNT)) u_back (.clock, .reset,
      .q_valid(cnt_ff != 2'd0), .q_data(head), .q_pop(pop), .idle(back_idle),
      .rsp_valid, .rsp_cell_direction, .rsp_cell_density, .rsp_cell_exponent,
      .rsp_cell_coefficient);

   assign busy = front_busy;

   `GBA_ASSERT_IMP(a_no_overflow, clock, reset, cnt_ff == 2'd2, !push)
   `GBA_ASSERT_IMP(a_no_underflow, clock, reset, cnt_ff == 2'd0, !pop)
   `GBA_ASSERT_IMP(a_idle_empty, clock, reset, back_idle, cnt_ff == 2'd0)
   `GBA_ASSERT_NEXT(a_rsp_strobe, clock, reset, rsp_valid, !rsp_valid)
endmodule
`default_nettype wire
